// File: rtl/tccb_pkg.sv
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared constants, codes and address helpers of the text console cell buffer.
// ----------------------------------------------------------------------------
package tccb_pkg;

  // Geometry of the character store
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CUR_W  = (ADDR_W > 11) ? ADDR_W : 11;
  localparam int TAB_W  = $clog2(TAB_SPACES + 1);

  // Reciprocal of COLUMNS, exact for every cell index of the store
  localparam int DIV_SHIFT = 24;
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + COLUMNS - 1) / COLUMNS;

  // Field widths of the transactions
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LOWEST    = 8'd31;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h00;

  // Map a logical row onto the physical row of the circular store
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] row);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, row};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Linear memory address of a physical row and a column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// File: rtl/tccb_ram.sv
// ----------------------------------------------------------------------------
// tccb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tccb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/text_console_cell_buffer.sv
// ----------------------------------------------------------------------------
// text_console_cell_buffer
// Character cell store of a text console with cursor, scrolling and clear.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns one result for each.
// The cells live in one RAM used as a circular store of rows: scrolling only
// moves the top-row pointer and marks the new last row blank (zero), and
// clear marks every row blank (space) at once, as reset marks every row blank
// (zero), so no clearing pass runs. A row marked blank is swept with its fill
// byte, one cell a cycle, before the first write into it. A printable byte
// writes one cell, backspace steps back and writes a space, tab writes
// TAB_SPACES spaces and newline fills the rest of the row with spaces. A read
// finds the row of the cell index by a multiplication with the reciprocal of
// COLUMNS and the column by one subtraction, then reads the cell, or takes the
// fill byte when the row is still blank. Clear, dropped bytes, reads beyond
// the store and unknown opcodes go straight to the result. The next transaction
// is accepted while a result still waits in the output register.
// ----------------------------------------------------------------------------
module text_console_cell_buffer (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_byte, [18:8] cell_index, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] read_data, [18:8] cursor_pos, [19] repaint
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;
  localparam logic [2:0] S_RDCELL = 3'd6;

  // Kinds of write run
  localparam logic [1:0] K_CHAR = 2'd0;
  localparam logic [1:0] K_TAB  = 2'd1;
  localparam logic [1:0] K_NL   = 2'd2;
  localparam logic [1:0] K_BS   = 2'd3;

  localparam int COL_W = tccb_pkg::COL_W;
  localparam int ROW_W = tccb_pkg::ROW_W;
  localparam int CUR_W = tccb_pkg::CUR_W;
  localparam int QP_W  = tccb_pkg::IDX_W + tccb_pkg::DIV_SHIFT;

  // Input fields
  logic [tccb_pkg::OP_W-1:0]   in_op;
  logic [tccb_pkg::CHAR_W-1:0] in_char;
  logic [tccb_pkg::IDX_W-1:0]  in_idx;

  assign in_op   = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_idx  = in_tdata[18:8];

  // Registers
  logic [2:0]                   state_r, state_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [tccb_pkg::CHAR_W-1:0]  wchar_r, wchar_nxt;
  logic [tccb_pkg::TAB_W-1:0]   cnt_r, cnt_nxt;
  logic [ROW_W-1:0]             row_r, row_nxt;
  logic [COL_W-1:0]             col_r, col_nxt;
  logic [CUR_W-1:0]             cur_r, cur_nxt;
  logic [ROW_W-1:0]             base_r, base_nxt;
  logic [tccb_pkg::ROWS-1:0]    blank_r, blank_nxt;
  logic [tccb_pkg::ROWS-1:0]    fillsp_r, fillsp_nxt;
  logic [COL_W-1:0]             sw_col_r, sw_col_nxt;
  logic [ROW_W-1:0]             sw_row_r, sw_row_nxt;
  logic [tccb_pkg::IDX_W-1:0]   rem_r, rem_nxt;
  logic [ROW_W-1:0]             drow_r, drow_nxt;
  logic [tccb_pkg::CHAR_W-1:0]  rdata_r, rdata_nxt;
  logic                         rep_r, rep_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tccb_pkg::CHAR_W-1:0]  out_data_r, out_data_nxt;
  logic [10:0]                  out_cur_r, out_cur_nxt;
  logic                         out_rep_r, out_rep_nxt;

  // RAM port signals
  logic                         ram_we;
  logic [tccb_pkg::ADDR_W-1:0]  ram_wa;
  logic [tccb_pkg::CHAR_W-1:0]  ram_wd;
  logic                         ram_re;
  logic [tccb_pkg::ADDR_W-1:0]  ram_ra;
  logic [tccb_pkg::CHAR_W-1:0]  ram_rd;

  // Cursor and division helpers
  logic [ROW_W-1:0] cur_phys;
  logic [ROW_W-1:0] div_phys;
  logic [QP_W-1:0]  quot_prod;

  assign cur_phys  = tccb_pkg::phys_row(base_r, row_r);
  assign div_phys  = tccb_pkg::phys_row(base_r, drow_r);
  assign quot_prod = QP_W'(in_idx) * QP_W'(tccb_pkg::DIV_MULT);

  tccb_ram #(
    .WIDTH (tccb_pkg::CHAR_W),
    .DEPTH (tccb_pkg::CELL_COUNT)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_rep_r, out_cur_r, out_data_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    wchar_nxt     = wchar_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cur_nxt       = cur_r;
    base_nxt      = base_r;
    blank_nxt     = blank_r;
    fillsp_nxt    = fillsp_r;
    sw_col_nxt    = sw_col_r;
    sw_row_nxt    = sw_row_r;
    rem_nxt       = rem_r;
    drow_nxt      = drow_r;
    rdata_nxt     = rdata_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_cur_nxt   = out_cur_r;
    out_rep_nxt   = out_rep_r;
    ram_we        = 1'b0;
    ram_wa        = tccb_pkg::cell_addr(cur_phys, col_r);
    ram_wd        = wchar_r;
    ram_re        = 1'b0;
    ram_ra        = tccb_pkg::cell_addr(div_phys, rem_r[COL_W-1:0]);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rdata_nxt = tccb_pkg::CH_ZERO;
          rep_nxt   = 1'b0;
          state_nxt = S_DONE;
          unique case (in_op)
            tccb_pkg::OP_PUT: begin
              // Decode the control characters, drop bytes below 31 and bytes with bit 7 set
              if (in_char == tccb_pkg::CH_NEWLINE) begin
                kind_nxt  = K_NL;
                wchar_nxt = tccb_pkg::CH_SPACE;
                rep_nxt   = 1'b1;
                state_nxt = S_WRITE;
              end else if (in_char == tccb_pkg::CH_TAB) begin
                kind_nxt  = K_TAB;
                wchar_nxt = tccb_pkg::CH_SPACE;
                cnt_nxt   = tccb_pkg::TAB_W'(tccb_pkg::TAB_SPACES);
                rep_nxt   = 1'b1;
                state_nxt = S_WRITE;
              end else if (in_char == tccb_pkg::CH_BACKSPACE) begin
                if (cur_r != '0) begin
                  kind_nxt  = K_BS;
                  wchar_nxt = tccb_pkg::CH_SPACE;
                  rep_nxt   = 1'b1;
                  state_nxt = S_WRITE;
                  cur_nxt   = cur_r - CUR_W'(1);
                  if (col_r == '0) begin
                    row_nxt = row_r - ROW_W'(1);
                    col_nxt = COL_W'(tccb_pkg::COLUMNS - 1);
                  end else begin
                    col_nxt = col_r - COL_W'(1);
                  end
                end
              end else if (in_char >= tccb_pkg::CH_LOWEST && !in_char[7]) begin
                kind_nxt  = K_CHAR;
                wchar_nxt = in_char;
                state_nxt = S_WRITE;
              end
            end
            tccb_pkg::OP_READ: begin
              // Take the row by reciprocal multiplication unless off the store
              if (32'(in_idx) < 32'(tccb_pkg::CELL_COUNT)) begin
                rem_nxt   = in_idx;
                drow_nxt  = quot_prod[tccb_pkg::DIV_SHIFT +: ROW_W];
                state_nxt = S_DIV;
              end
            end
            tccb_pkg::OP_CLEAR: begin
              blank_nxt  = '1;
              fillsp_nxt = '1;
              base_nxt   = '0;
              row_nxt    = '0;
              col_nxt    = '0;
              cur_nxt    = '0;
              rep_nxt    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_WRITE: begin
        if (blank_r[cur_phys]) begin
          // Materialize the blank row before touching it
          sw_row_nxt = cur_phys;
          sw_col_nxt = '0;
          state_nxt  = S_SWEEP;
        end else begin
          ram_we = 1'b1;
          if (kind_r == K_BS) begin
            state_nxt = S_DONE;
          end else begin
            // Advance the cursor, scroll past the last cell
            if (col_r == COL_W'(tccb_pkg::COLUMNS - 1)) begin
              col_nxt = '0;
              if (row_r == ROW_W'(tccb_pkg::ROWS - 1)) begin
                blank_nxt[base_r]  = 1'b1;
                fillsp_nxt[base_r] = 1'b0;
                base_nxt = (base_r == ROW_W'(tccb_pkg::ROWS - 1)) ? '0 :
                           base_r + ROW_W'(1);
                cur_nxt  = CUR_W'(tccb_pkg::CELL_COUNT - tccb_pkg::COLUMNS);
              end else begin
                row_nxt = row_r + ROW_W'(1);
                cur_nxt = cur_r + CUR_W'(1);
              end
            end else begin
              col_nxt = col_r + COL_W'(1);
              cur_nxt = cur_r + CUR_W'(1);
            end
            case (kind_r)
              K_TAB: begin
                if (cnt_r == tccb_pkg::TAB_W'(1)) begin
                  state_nxt = S_DONE;
                end else begin
                  cnt_nxt = cnt_r - tccb_pkg::TAB_W'(1);
                end
              end
              K_NL: begin
                if (col_r == COL_W'(tccb_pkg::COLUMNS - 1)) begin
                  state_nxt = S_DONE;
                end
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_SWEEP: begin
        // Write the fill byte across the row, one cell a cycle
        ram_we = 1'b1;
        ram_wa = tccb_pkg::cell_addr(sw_row_r, sw_col_r);
        ram_wd = fillsp_r[sw_row_r] ? tccb_pkg::CH_SPACE : tccb_pkg::CH_ZERO;
        if (sw_col_r == COL_W'(tccb_pkg::COLUMNS - 1)) begin
          blank_nxt[sw_row_r] = 1'b0;
          state_nxt           = S_WRITE;
        end else begin
          sw_col_nxt = sw_col_r + COL_W'(1);
        end
      end

      S_DIV: begin
        // Strip the row offset from the index to leave the column
        rem_nxt   = rem_r - tccb_pkg::IDX_W'(drow_r) *
                            tccb_pkg::IDX_W'(tccb_pkg::COLUMNS);
        state_nxt = S_RDCELL;
      end

      S_RDCELL: begin
        // Read the cell, or take the fill byte of a blank row
        if (blank_r[div_phys]) begin
          rdata_nxt = fillsp_r[div_phys] ? tccb_pkg::CH_SPACE : tccb_pkg::CH_ZERO;
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_RDWAIT;
        end
      end

      S_RDWAIT: begin
        rdata_nxt = ram_rd;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rdata_r;
          out_cur_nxt   = cur_r[10:0];
          out_rep_nxt   = rep_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      cur_r       <= '0;
      base_r      <= '0;
      blank_r     <= '1;
      fillsp_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cur_r       <= cur_nxt;
      base_r      <= base_nxt;
      blank_r     <= blank_nxt;
      fillsp_r    <= fillsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    wchar_r    <= wchar_nxt;
    cnt_r      <= cnt_nxt;
    sw_col_r   <= sw_col_nxt;
    sw_row_r   <= sw_row_nxt;
    rem_r      <= rem_nxt;
    drow_r     <= drow_nxt;
    rdata_r    <= rdata_nxt;
    rep_r      <= rep_nxt;
    out_data_r <= out_data_nxt;
    out_cur_r  <= out_cur_nxt;
    out_rep_r  <= out_rep_nxt;
  end

endmodule
